// File: hw/rtl/mbsp_pkg.sv
// Shared types, constants and helpers for the MIDI byte stream parser.
`default_nettype none

package mbsp_pkg;

  // Largest sysex length that is counted; the count saturates here.
  localparam int SYSEX_MAX = 1024;

  // Width of the sysex length field and its largest value.
  localparam int LEN_W       = 11;
  localparam int LEN_MAX_INT = (1 << LEN_W) - 1;
  localparam int LEN_CAP_INT = (SYSEX_MAX > LEN_MAX_INT) ? LEN_MAX_INT : SYSEX_MAX;
  localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(LEN_CAP_INT);

  // Status bytes with a meaning of their own.
  localparam logic [7:0] STATUS_SYSEX_START = 8'hF0;
  localparam logic [7:0] STATUS_SYSEX_END   = 8'hF7;

  // Status groups (upper nibble of the running status).
  localparam logic [3:0] GRP_NOTE_OFF   = 4'h8;
  localparam logic [3:0] GRP_NOTE_ON    = 4'h9;
  localparam logic [3:0] GRP_POLY_PRESS = 4'hA;
  localparam logic [3:0] GRP_CONTROL    = 4'hB;
  localparam logic [3:0] GRP_PROGRAM    = 4'hC;
  localparam logic [3:0] GRP_CHAN_PRESS = 4'hD;
  localparam logic [3:0] GRP_PITCH_BEND = 4'hE;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_THREE_BYTE = 2'd0,
    KIND_TWO_BYTE   = 2'd1,
    KIND_SYSEX_END  = 2'd2
  } kind_t;

  // Parser state carried from one byte to the next.
  typedef struct packed {
    logic [7:0]       running_status;
    logic [6:0]       held_data;
    logic [LEN_W-1:0] byte_position;
    logic             in_sysex;
  } parse_state_t;

  // One result beat.
  typedef struct packed {
    kind_t            kind;
    logic [7:0]       status_byte;
    logic [6:0]       first_data;
    logic [6:0]       second_data;
    logic [LEN_W-1:0] sysex_length;
  } result_t;

  // Saturating increment of the sysex byte count.
  function automatic logic [LEN_W-1:0] count_up(input logic [LEN_W-1:0] n);
    count_up = (n >= LEN_CAP) ? LEN_CAP : n + LEN_W'(1);
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/mbsp_decode.sv
// Combinational decode of one MIDI byte against the running parser state.
`default_nettype none

module mbsp_decode
  import mbsp_pkg::*;
(
  input  wire logic [7:0]   midi_byte,
  input  wire parse_state_t state,
  output parse_state_t      state_next,
  output logic              res_valid,
  output result_t           res
);

  // Status bytes, sysex counting and channel message assembly.
  always_comb begin
    state_next = state;
    res_valid  = 1'b0;
    res        = '{kind: KIND_THREE_BYTE, status_byte: 8'h00, first_data: 7'h00,
                   second_data: 7'h00, sysex_length: '0};

    if (midi_byte[7]) begin
      // Any status byte replaces the running status.
      state_next.running_status = midi_byte;
      if (midi_byte == STATUS_SYSEX_START) begin
        state_next.in_sysex      = 1'b1;
        state_next.byte_position = LEN_W'(1);
      end else begin
        state_next.in_sysex      = 1'b0;
        state_next.byte_position = '0;
        if (midi_byte == STATUS_SYSEX_END) begin
          res_valid        = 1'b1;
          res.kind         = KIND_SYSEX_END;
          res.status_byte  = midi_byte;
          res.sysex_length = state.in_sysex ? count_up(state.byte_position)
                                            : LEN_W'(1);
        end
      end
    end else if (state.in_sysex) begin
      // Data inside sysex is only counted.
      state_next.byte_position = count_up(state.byte_position);
    end else begin
      case (state.running_status[7:4])
        GRP_NOTE_OFF, GRP_NOTE_ON, GRP_POLY_PRESS, GRP_CONTROL, GRP_PITCH_BEND: begin
          if (state.byte_position == '0) begin
            state_next.held_data     = midi_byte[6:0];
            state_next.byte_position = LEN_W'(1);
          end else begin
            state_next.byte_position = '0;
            res_valid       = 1'b1;
            res.kind        = KIND_THREE_BYTE;
            res.status_byte = state.running_status;
            res.first_data  = state.held_data;
            res.second_data = midi_byte[6:0];
          end
        end
        GRP_PROGRAM, GRP_CHAN_PRESS: begin
          state_next.held_data     = midi_byte[6:0];
          state_next.byte_position = '0;
          res_valid       = 1'b1;
          res.kind        = KIND_TWO_BYTE;
          res.status_byte = state.running_status;
          res.first_data  = midi_byte[6:0];
        end
        default: begin
          // No usable running status: the data byte is dropped.
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/midi_byte_stream_parser_core.sv
// Top level of the MIDI byte stream parser with output register and skid stage.
`default_nettype none

// MIDI byte stream parser. One raw MIDI byte enters per beat on the slave side, and
// the block sustains one byte per clock while the skid stage is empty. The running
// status, the held first data byte, the data position or sysex count and the sysex
// flag are updated in the same cycle the byte is accepted; a finished message is
// registered in the output register, or in a second result register (skid stage)
// while the master side is stalled, so the input keeps flowing for one more beat;
// s_tready drops only while that skid stage is occupied. The result kind travels
// on m_tuser; sysex lengths include F0 and F7 and saturate at 1024.
module midi_byte_stream_parser_core
  import mbsp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,

  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] midi_byte

  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // [7:0] status_byte, [14:8] first_data,
                                      // [21:15] second_data, [32:22] sysex_length,
                                      // [39:33] zero
  output logic [1:0]       m_tuser    // [1:0] kind
);

  parse_state_t state;
  parse_state_t state_next;
  logic         res_valid;
  result_t      res;

  result_t      main_res;
  result_t      skid_res;
  logic         skid_valid;

  logic         accept;
  logic         push;
  logic         pop;

  mbsp_decode u_decode (
    .midi_byte  (s_tdata),
    .state      (state),
    .state_next (state_next),
    .res_valid  (res_valid),
    .res        (res)
  );

  assign s_tready = !skid_valid;
  assign accept   = s_tvalid && s_tready;
  assign push     = accept && res_valid;
  assign pop      = m_tvalid && m_tready;

  // Parser state advances on every accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (accept) begin
      state <= state_next;
    end
  end

  // Output register backed by a one-entry skid stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!m_tvalid || pop) begin
      if (skid_valid) begin
        main_res   <= skid_res;
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end else if (push) begin
        main_res <= res;
        m_tvalid <= 1'b1;
      end else begin
        m_tvalid <= 1'b0;
      end
    end else if (push) begin
      skid_res   <= res;
      skid_valid <= 1'b1;
    end
  end

  // Pack the result beat.
  assign m_tuser = main_res.kind;
  assign m_tdata = {7'd0, main_res.sysex_length, main_res.second_data,
                    main_res.first_data, main_res.status_byte};

  // The skid stage only fills behind a held output beat.
  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid)
    else $error("skid stage holds a beat while the output register is empty");

  // Inside sysex the count always includes at least the F0.
  a_sysex_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    state.in_sysex |-> (state.byte_position != '0))
    else $error("sysex active with a zero byte count");

  // The count never passes the saturation limit.
  a_count_capped: assert property (@(posedge clk) disable iff (rst)
    state.byte_position <= LEN_CAP)
    else $error("byte position above the sysex cap");

  // Outside sysex the position only marks whether a first data byte is held.
  a_channel_position: assert property (@(posedge clk) disable iff (rst)
    !state.in_sysex |-> (state.byte_position <= LEN_W'(1)))
    else $error("channel message position out of range");

endmodule

`default_nettype wire

// File: bench/tb.sv
// Self-checking testbench for the MIDI byte stream parser core.

module tb;
  import mbsp_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned RANDOM_BYTES = 1850;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned MAX_REPORTS  = 10;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic [1:0]  m_tuser;

  // Bytes waiting to be sent and messages the parser still owes.
  logic [7:0]  pending_bytes[$];
  result_t     expected_msgs[$];

  // Shadow copy of the parser state.
  logic [7:0]       run_status = 8'h00;
  logic [6:0]       held_first = 7'h00;
  logic [LEN_W-1:0] data_pos = '0;
  logic             in_sysex = 1'b0;

  int unsigned cycle_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned stall_phase = 0;
  int unsigned stall_mode = 0;
  logic [7:0]  stall_mask = 8'hFF;
  result_t     decoded_msg;
  result_t     seen_msg;
  result_t     owed_msg;

  midi_byte_stream_parser_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Sysex byte count that stops at the length cap.
  function automatic logic [LEN_W-1:0] sysex_count_step(input logic [LEN_W-1:0] n);
    return (n >= LEN_CAP) ? LEN_CAP : n + LEN_W'(1);
  endfunction

  // Advances the shadow state by one byte; returns 1 when a message completes.
  function automatic bit decode_midi_byte(input logic [7:0] b, output result_t msg);
    msg = '0;
    if (b[7]) begin
      run_status = b;
      if (b == STATUS_SYSEX_START) begin
        in_sysex = 1'b1;
        data_pos = LEN_W'(1);
        return 1'b0;
      end
      if (b == STATUS_SYSEX_END) begin
        msg.kind = KIND_SYSEX_END;
        msg.status_byte = b;
        msg.sysex_length = in_sysex ? sysex_count_step(data_pos) : LEN_W'(1);
        in_sysex = 1'b0;
        data_pos = '0;
        return 1'b1;
      end
      // Any other status byte ends sysex silently.
      in_sysex = 1'b0;
      data_pos = '0;
      return 1'b0;
    end
    if (in_sysex) begin
      data_pos = sysex_count_step(data_pos);
      return 1'b0;
    end
    case (run_status[7:4])
      GRP_NOTE_OFF, GRP_NOTE_ON, GRP_POLY_PRESS, GRP_CONTROL, GRP_PITCH_BEND: begin
        if (data_pos == '0) begin
          held_first = b[6:0];
          data_pos = LEN_W'(1);
          return 1'b0;
        end
        data_pos = '0;
        msg.kind = KIND_THREE_BYTE;
        msg.status_byte = run_status;
        msg.first_data = held_first;
        msg.second_data = b[6:0];
        return 1'b1;
      end
      GRP_PROGRAM, GRP_CHAN_PRESS: begin
        held_first = b[6:0];
        data_pos = '0;
        msg.kind = KIND_TWO_BYTE;
        msg.status_byte = run_status;
        msg.first_data = b[6:0];
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Appends one random byte sequence, mostly well-formed MIDI traffic.
  task automatic queue_random_sequence();
    int unsigned pick;
    int unsigned n;
    logic [7:0]  st;
    logic [7:0]  sys;
    pick = $urandom_range(0, 99);
    st = {1'b1, 3'($urandom_range(0, 6)), 4'($urandom)};
    sys = 8'($urandom_range(8'hF1, 8'hFF));
    if (sys == STATUS_SYSEX_END) begin
      sys = 8'hF8;
    end
    if (pick < 55) begin
      // Channel message followed by running-status repeats.
      pending_bytes.push_back(st);
      n = $urandom_range(1, 4);
      repeat (n) begin
        pending_bytes.push_back(8'($urandom_range(0, 127)));
        if (st[7:4] != GRP_PROGRAM && st[7:4] != GRP_CHAN_PRESS) begin
          pending_bytes.push_back(8'($urandom_range(0, 127)));
        end
      end
    end else if (pick < 70) begin
      // Short sysex, usually closed by F7, sometimes restarted or cut off.
      pending_bytes.push_back(STATUS_SYSEX_START);
      n = $urandom_range(0, 12);
      repeat (n) pending_bytes.push_back(8'($urandom_range(0, 127)));
      n = $urandom_range(0, 9);
      if (n == 0) begin
        pending_bytes.push_back(STATUS_SYSEX_START);
        repeat ($urandom_range(0, 4)) pending_bytes.push_back(8'($urandom_range(0, 127)));
        pending_bytes.push_back(STATUS_SYSEX_END);
      end else if (n == 1) begin
        pending_bytes.push_back((pick[0]) ? sys : st);
      end else begin
        pending_bytes.push_back(STATUS_SYSEX_END);
      end
    end else if (pick < 80) begin
      // Channel message cut short by the next status.
      pending_bytes.push_back(st);
      pending_bytes.push_back(8'($urandom_range(0, 127)));
    end else if (pick < 88) begin
      // System status kills running status; following data is dropped.
      pending_bytes.push_back(sys);
      repeat ($urandom_range(0, 2)) pending_bytes.push_back(8'($urandom_range(0, 127)));
    end else if (pick < 94) begin
      // Real-time byte in the middle of a channel message.
      pending_bytes.push_back(st);
      pending_bytes.push_back(8'($urandom_range(0, 127)));
      pending_bytes.push_back(8'($urandom_range(8'hF8, 8'hFF)));
      pending_bytes.push_back(8'($urandom_range(0, 127)));
    end else begin
      // Raw noise.
      repeat ($urandom_range(1, 3)) pending_bytes.push_back(8'($urandom));
    end
  endtask

  // Driver: sends queued bytes in bursts separated by random gaps.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= 8'h00;
      burst_left <= $urandom_range(1, 40);
      gap_left <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        if (decode_midi_byte(s_tdata, decoded_msg)) begin
          expected_msgs.push_back(decoded_msg);
        end
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          s_tvalid <= 1'b0;
        end else if (pending_bytes.size() != 0) begin
          s_tvalid <= 1'b1;
          s_tdata <= pending_bytes.pop_front();
          if (burst_left <= 1) begin
            burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                       : $urandom_range(1, 40);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver back-pressure: a stall pattern that changes whenever stall_phase[5:0] wraps.
  always @(posedge clk) begin
    stall_phase <= stall_phase + 1;
    if (stall_phase[5:0] == 6'd63) begin
      stall_mode <= $urandom_range(0, 3);
      stall_mask <= 8'($urandom);
    end
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= 1'($urandom_range(0, 1));
      2: m_tready <= (stall_phase[1:0] == 2'd0);
      default: m_tready <= stall_mask[stall_phase[2:0]];
    endcase
  end

  // Monitor: compares each result beat with the oldest owed message.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      seen_msg.kind = kind_t'(m_tuser);
      seen_msg.status_byte = m_tdata[7:0];
      seen_msg.first_data = m_tdata[14:8];
      seen_msg.second_data = m_tdata[21:15];
      seen_msg.sysex_length = m_tdata[32:22];
      if (expected_msgs.size() == 0) begin
        if (mismatch_count < MAX_REPORTS) begin
          $display("unexpected beat: kind %0d status %02h d1 %02h d2 %02h len %0d",
                   seen_msg.kind, seen_msg.status_byte, seen_msg.first_data,
                   seen_msg.second_data, seen_msg.sysex_length);
        end
        mismatch_count <= mismatch_count + 1;
      end else begin
        owed_msg = expected_msgs.pop_front();
        if (seen_msg.kind !== owed_msg.kind ||
            seen_msg.status_byte !== owed_msg.status_byte ||
            seen_msg.first_data !== owed_msg.first_data ||
            seen_msg.second_data !== owed_msg.second_data ||
            seen_msg.sysex_length !== owed_msg.sysex_length) begin
          if (mismatch_count < MAX_REPORTS) begin
            $display("bad beat: expected kind %0d status %02h d1 %02h d2 %02h len %0d",
                     owed_msg.kind, owed_msg.status_byte, owed_msg.first_data,
                     owed_msg.second_data, owed_msg.sysex_length);
            $display("          got      kind %0d status %02h d1 %02h d2 %02h len %0d",
                     seen_msg.kind, seen_msg.status_byte, seen_msg.first_data,
                     seen_msg.second_data, seen_msg.sysex_length);
          end
          mismatch_count <= mismatch_count + 1;
        end
      end
    end
  end

  // Watchdog on the cycle count.
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("midi_byte_stream_parser_core: mismatch");
    $finish;
  end

  // Stimulus, reset and end of run.
  initial begin
    // Directed bytes: data before any status, extremes, running status, two-byte
    // groups, F7 outside sysex, F0 restart inside sysex, a channel status ending
    // sysex, a real-time byte ending sysex, and a system status dropping data.
    pending_bytes = '{8'h00, 8'h7F, 8'h90, 8'h00, 8'h7F, 8'h45, 8'hC5, 8'h7F,
                      8'h00, 8'hF7, 8'hF0, 8'h01, 8'hF0, 8'h02, 8'hF7, 8'hF0,
                      8'h10, 8'h9A, 8'h11, 8'h22, 8'hF0, 8'hF8, 8'h05, 8'hEF,
                      8'h7F, 8'h7F, 8'hDF, 8'h33};
    // One sysex long enough to hit the length cap.
    pending_bytes.push_back(STATUS_SYSEX_START);
    repeat (int'(LEN_CAP) + 6) pending_bytes.push_back(8'($urandom_range(0, 127)));
    pending_bytes.push_back(STATUS_SYSEX_END);
    while (pending_bytes.size() < RANDOM_BYTES) begin
      queue_random_sequence();
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (pending_bytes.size() != 0 || s_tvalid) @(posedge clk);
    while (expected_msgs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("midi_byte_stream_parser_core: match");
    end else begin
      $display("midi_byte_stream_parser_core: mismatch");
    end
    $finish;
  end

endmodule
